// ----- src/c3x3_pkg.sv -----
package c3x3_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int SZW   = 13;
    localparam int OCW   = 10;
    localparam int SUMW  = 20;
    localparam int PXW   = 24;
    localparam int CFGW  = 24;
    localparam int CIDXW = 3;

    localparam logic [CIDXW-1:0] REG_COEF_TOP  = 3'd0;
    localparam logic [CIDXW-1:0] REG_COEF_MID  = 3'd1;
    localparam logic [CIDXW-1:0] REG_COEF_BOT  = 3'd2;
    localparam logic [CIDXW-1:0] REG_DIVISOR   = 3'd3;
    localparam logic [CIDXW-1:0] REG_WIDTH     = 3'd4;
    localparam logic [CIDXW-1:0] REG_HEIGHT    = 3'd5;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       frame_start;
    } t_in;

    typedef struct packed {
        logic [7:0]     red_out;
        logic [7:0]     green_out;
        logic [7:0]     blue_out;
        logic [OCW-1:0] out_column;
        logic [OCW-1:0] out_row;
        logic           frame_end;
    } t_out;

    typedef struct packed {
        logic       start;
        logic [7:0] divisor;
    } t_div_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MAC,
        S_DIV,
        S_OUT
    } t_state;

    function automatic logic signed [7:0] tap_coef(input logic [71:0] rows,
                                                   input logic [3:0] k);
        logic signed [7:0] c;
        case (k)
            4'd0: c = rows[7:0];
            4'd1: c = rows[15:8];
            4'd2: c = rows[23:16];
            4'd3: c = rows[31:24];
            4'd4: c = rows[39:32];
            4'd5: c = rows[47:40];
            4'd6: c = rows[55:48];
            4'd7: c = rows[63:56];
            4'd8: c = rows[71:64];
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage

// ----- src/conv3x3_rgb_clamp_divide_core.sv -----
// channel | signals                          | direction
// input   | i_valid, o_ready, i_data (t_in)  | in
// output  | o_valid, i_ready, o_data (t_out) | out
// config  | i_cfg_we, i_cfg_idx, i_cfg_data  | in
// a border pixel passes accept and line store read only; an interior pixel goes through
// accept, line store read, the taps with one multiplier per plane, the divider, output load
// synchronous active-low reset clears counters and window columns and presets the
// config registers to defaults; line stores and the tap window are not cleared
// the output register holds an item until taken; the next item is accepted meanwhile
// an interior item waits in output load while the output register is full and not taken
module conv3x3_rgb_clamp_divide_core import c3x3_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in              i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output t_out             o_data,
    input  logic             i_cfg_we,
    input  logic [CIDXW-1:0] i_cfg_idx,
    input  logic [CFGW-1:0]  i_cfg_data
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    t_state r_state, n_state;

    logic [23:0] r_coef_top, r_coef_mid, r_coef_bot;
    logic [7:0]  r_divisor;
    logic [10:0] r_width, r_height;

    logic [CW-1:0] r_c;
    logic [RW-1:0] r_r;
    logic [PXW-1:0] r_px;
    logic [PXW-1:0] r_wc [6];
    logic [PXW-1:0] r_win [9];
    logic [3:0]     r_k;
    logic signed [SUMW-1:0] r_acc [3];
    logic [OCW-1:0] r_ocol, r_orow;
    logic           r_fend;
    logic           r_ovalid;
    t_out           r_odata;

    logic [PXW-1:0] rd_old, rd_new;
    logic [SZW-1:0] eff_w, eff_h, c_ext, r_ext, c_nxt, r_nxt;
    logic           accept, produce, ram_we;
    logic [CW-1:0]  rd_addr;
    t_div_ctl       div_ctl;
    logic [7:0]     div_res [3];
    logic [2:0]     div_done;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign rd_addr = i_data.frame_start ? '0 : r_c;
    assign ram_we  = (r_state == S_LOAD);

    always_comb begin
        eff_w = SZW'(r_width);
        if (SZW'(r_width) < SZW'(3)) eff_w = SZW'(3);
        else if (SZW'(r_width) > SZW'(MAX_WIDTH)) eff_w = SZW'(MAX_WIDTH);
        eff_h = SZW'(r_height);
        if (SZW'(r_height) < SZW'(3)) eff_h = SZW'(3);
        else if (SZW'(r_height) > SZW'(MAX_HEIGHT)) eff_h = SZW'(MAX_HEIGHT);
    end

    assign c_ext   = SZW'(r_c);
    assign r_ext   = SZW'(r_r);
    assign c_nxt   = c_ext + SZW'(1);
    assign r_nxt   = r_ext + SZW'(1);
    assign produce = (r_ext >= SZW'(2)) && (c_ext >= SZW'(2))
                  && (r_ext < eff_h) && (c_ext < eff_w);

    c3x3_ram #(.W(PXW), .D(MAX_WIDTH)) u_older (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(r_c), .i_wdata(rd_new),
        .i_raddr(rd_addr), .o_rdata(rd_old)
    );

    c3x3_ram #(.W(PXW), .D(MAX_WIDTH)) u_newer (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(r_c), .i_wdata(r_px),
        .i_raddr(rd_addr), .o_rdata(rd_new)
    );

    assign div_ctl.start   = (r_state == S_MAC) && (r_k == 4'd9);
    assign div_ctl.divisor = r_divisor;

    for (genvar p = 0; p < 3; p++) begin : g_plane
        c3x3_div u_div (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(div_ctl),
            .i_sum(r_acc[p]), .o_res(div_res[p]), .o_done(div_done[p])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_LOAD;
            S_LOAD: n_state = produce ? S_MAC : S_IDLE;
            S_MAC:  if (r_k == 4'd9) n_state = S_DIV;
            S_DIV:  if (div_done[0]) n_state = S_OUT;
            S_OUT:  if (!r_ovalid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_top <= 24'd0;
            r_coef_mid <= 24'd256;
            r_coef_bot <= 24'd0;
            r_divisor  <= 8'd1;
            r_width    <= 11'd1024;
            r_height   <= 11'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_COEF_TOP: r_coef_top <= i_cfg_data;
                REG_COEF_MID: r_coef_mid <= i_cfg_data;
                REG_COEF_BOT: r_coef_bot <= i_cfg_data;
                REG_DIVISOR:  r_divisor  <= i_cfg_data[7:0];
                REG_WIDTH:    r_width    <= i_cfg_data[10:0];
                REG_HEIGHT:   r_height   <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= '0;
            r_r <= '0;
            r_k <= 4'd0;
            for (int i = 0; i < 6; i++) r_wc[i] <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (accept && i_data.frame_start) begin
                    r_c <= '0;
                    r_r <= '0;
                end
                S_LOAD: begin
                    r_k   <= 4'd0;
                    r_wc[0] <= r_wc[3];
                    r_wc[1] <= r_wc[4];
                    r_wc[2] <= r_wc[5];
                    r_wc[3] <= rd_old;
                    r_wc[4] <= rd_new;
                    r_wc[5] <= r_px;
                    if (c_nxt >= eff_w) begin
                        r_c <= '0;
                        r_r <= (r_nxt >= eff_h) ? '0 : RW'(r_nxt);
                    end else begin
                        r_c <= CW'(c_nxt);
                    end
                end
                S_MAC: if (r_k != 4'd9) r_k <= r_k + 4'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [7:0]  coef;
        logic signed [16:0] prod;
        if (accept) begin
            r_px <= {i_data.blue_in, i_data.green_in, i_data.red_in};
        end
        if (r_state == S_LOAD) begin
            r_win[0] <= r_wc[0]; r_win[3] <= r_wc[1]; r_win[6] <= r_wc[2];
            r_win[1] <= r_wc[3]; r_win[4] <= r_wc[4]; r_win[7] <= r_wc[5];
            r_win[2] <= rd_old;  r_win[5] <= rd_new;  r_win[8] <= r_px;
            for (int p = 0; p < 3; p++) r_acc[p] <= '0;
            r_ocol <= OCW'(c_ext - SZW'(1));
            r_orow <= OCW'(r_ext - SZW'(1));
            r_fend <= (r_ext == eff_h - SZW'(1)) && (c_ext == eff_w - SZW'(1));
        end else if (r_state == S_MAC && r_k != 4'd9) begin
            coef = tap_coef({r_coef_bot, r_coef_mid, r_coef_top}, r_k);
            for (int p = 0; p < 3; p++) begin
                prod = 17'($signed({1'b0, r_win[r_k[3:0]][8*p +: 8]}) * coef);
                r_acc[p] <= r_acc[p] + SUMW'(prod);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && (!r_ovalid || i_ready)) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ovalid || i_ready)) begin
            r_odata.red_out    <= div_res[0];
            r_odata.green_out  <= div_res[1];
            r_odata.blue_out   <= div_res[2];
            r_odata.out_column <= r_ocol;
            r_odata.out_row    <= r_orow;
            r_odata.frame_end  <= r_fend;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_LOAD))
        else $error("accepted item not followed by line store access");

    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_k <= 4'd9))
        else $error("tap counter out of range");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_OUT))
        else $error("result loaded outside output state");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done[0] |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");
endmodule

// ----- src/c3x3_ram.sv -----
module c3x3_ram #(
    parameter int W = 24,
    parameter int D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/c3x3_div.sv -----
module c3x3_div import c3x3_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_div_ctl               i_ctl,
    input  logic signed [SUMW-1:0] i_sum,
    output logic [7:0]             o_res,
    output logic                   o_done
);
    logic [7:0]  r_rem, n_rem;
    logic [7:0]  r_low, n_low;
    logic [7:0]  r_q, n_q;
    logic [7:0]  r_div;
    logic [2:0]  r_cnt;
    logic        r_busy, r_done, r_hi, r_zero;
    logic [15:0] lim;
    logic [8:0]  t;

    assign lim = 16'({8'd0, i_ctl.divisor} * 16'd255);
    assign t   = {r_rem, r_low[7]};

    always_comb begin
        n_low = {r_low[6:0], 1'b0};
        if (t >= {1'b0, r_div}) begin
            n_rem = 8'(t - {1'b0, r_div});
            n_q   = {r_q[6:0], 1'b1};
        end else begin
            n_rem = t[7:0];
            n_q   = {r_q[6:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_div  <= i_ctl.divisor;
            r_rem  <= i_sum[15:8];
            r_low  <= i_sum[7:0];
            r_q    <= 8'd0;
            r_zero <= i_sum[SUMW-1] || (i_ctl.divisor == 8'd0);
            r_hi   <= !i_sum[SUMW-1] && ({1'b0, i_sum[SUMW-2:0]} > SUMW'(lim));
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= n_low;
            r_q   <= n_q;
        end
    end

    assign o_res  = r_hi ? 8'd255 : (r_zero ? 8'd0 : r_q);
    assign o_done = r_done;
endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import c3x3_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    t_in              in_data;
    logic             out_valid;
    logic             out_ready;
    t_out             out_data;
    logic             cfg_we;
    logic [CIDXW-1:0] cfg_idx;
    logic [CFGW-1:0]  cfg_data;

    conv3x3_rgb_clamp_divide_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_ready    (in_ready),
        .i_data     (in_data),
        .o_valid    (out_valid),
        .i_ready    (out_ready),
        .o_data     (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    localparam int DRAIN_CYCLES = 60;

    // filter model state
    logic [23:0] line_old [DEF_MAX_WIDTH];
    logic [23:0] line_new [DEF_MAX_WIDTH];
    logic [23:0] win_cols [6];
    int unsigned pos_col;
    int unsigned pos_row;
    int          max_idx_written;
    logic [23:0] k_top, k_mid, k_bot;
    logic [7:0]  div_r;
    logic [10:0] width_r, height_r;

    t_out pixel_q [$];
    int   fails;
    int   n_sent;
    int   n_got;
    int   n_phases;
    bit   send_idle_on;

    typedef struct {
        bit          is_cfg;
        logic [23:0] regs [6];
        t_in         px;
        bit          has_exp;
        t_out        exp;
    } t_row;

    t_row dir_rows [$];

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int unsigned eff_dim(logic [10:0] v);
        if (v < 11'd3) return 3;
        if (v > 11'd1024) return 1024;
        return v;
    endfunction

    function automatic logic [7:0] clamp_div(int s);
        int lim;
        lim = 255 * int'(div_r);
        if (s < 0) return 8'd0;
        if (s > lim) return 8'd255;
        if (div_r == 8'd0) return 8'd0;
        return 8'(s / int'(div_r));
    endfunction

    function automatic bit filter_pixel(t_in p, output t_out r);
        int unsigned w, h, c, rw, idx;
        logic [23:0] pxv;
        logic [23:0] win [9];
        logic [71:0] kr;
        logic [7:0]  res [3];
        int          s;
        bit          hit;
        w = eff_dim(width_r);
        h = eff_dim(height_r);
        pxv = {p.blue_in, p.green_in, p.red_in};
        kr = {k_bot, k_mid, k_top};
        if (p.frame_start) begin
            pos_col = 0;
            pos_row = 0;
        end
        c = pos_col;
        rw = pos_row;
        idx = (c < DEF_MAX_WIDTH) ? c : DEF_MAX_WIDTH - 1;
        win[0] = win_cols[0]; win[3] = win_cols[1]; win[6] = win_cols[2];
        win[1] = win_cols[3]; win[4] = win_cols[4]; win[7] = win_cols[5];
        win[2] = line_old[idx]; win[5] = line_new[idx]; win[8] = pxv;
        hit = (rw >= 2) && (c >= 2) && (rw < h) && (c < w);
        r = '0;
        if (hit) begin
            for (int pl = 0; pl < 3; pl++) begin
                s = 0;
                for (int k = 0; k < 9; k++)
                    s += int'(win[k][8*pl +: 8]) * int'($signed(kr[8*k +: 8]));
                res[pl] = clamp_div(s);
            end
            r.red_out    = res[0];
            r.green_out  = res[1];
            r.blue_out   = res[2];
            r.out_column = OCW'(c - 1);
            r.out_row    = OCW'(rw - 1);
            r.frame_end  = (rw == h - 1) && (c == w - 1);
        end
        win_cols[0] = win[1]; win_cols[1] = win[4]; win_cols[2] = win[7];
        win_cols[3] = win[2]; win_cols[4] = win[5]; win_cols[5] = win[8];
        line_old[idx] = line_new[idx];
        line_new[idx] = pxv;
        if (int'(idx) > max_idx_written) max_idx_written = idx;
        c++;
        if (c >= w) begin
            c = 0;
            rw++;
            if (rw >= h) rw = 0;
        end
        pos_col = c;
        pos_row = rw;
        return hit;
    endfunction

    task automatic put_reg(logic [CIDXW-1:0] idx, logic [23:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_COEF_TOP: k_top = val;
            REG_COEF_MID: k_mid = val;
            REG_COEF_BOT: k_bot = val;
            REG_DIVISOR:  div_r = val[7:0];
            REG_WIDTH:    width_r = val[10:0];
            REG_HEIGHT:   height_r = val[10:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(logic [23:0] v [6]);
        in_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        put_reg(REG_COEF_TOP, v[0]);
        put_reg(REG_COEF_MID, v[1]);
        put_reg(REG_COEF_BOT, v[2]);
        put_reg(REG_DIVISOR, v[3]);
        put_reg(REG_WIDTH, v[4]);
        put_reg(REG_HEIGHT, v[5]);
        cfg_we <= 1'b0;
        n_phases++;
    endtask

    task automatic send_px(t_in p, bit use_typed, t_out typed);
        int   gap;
        t_out r;
        gap = send_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do @(posedge clk); while (!in_ready);
        n_sent++;
        if (filter_pixel(p, r) || use_typed)
            pixel_q.push_back(use_typed ? typed : r);
    endtask

    function automatic t_in rand_px(bit fs);
        t_in p;
        case ($urandom_range(0, 7))
            0: p = '0;
            1: p = '1;
            default: p = t_in'($urandom);
        endcase
        p.frame_start = fs;
        return p;
    endfunction

    function automatic logic [7:0] rand_coef();
        case ($urandom_range(0, 7))
            0: return 8'h7f;
            1: return 8'h80;
            2, 3: return 8'($signed($urandom_range(0, 8)) - 4);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] noisy(logic [23:0] v, int keep);
        logic [23:0] n;
        n = $urandom;
        if ($urandom_range(0, 1)) v = v | (n & ~((24'd1 << keep) - 24'd1));
        return v;
    endfunction

    // directed table
    task automatic add_cfg(logic [23:0] a, b, c, d, e, f);
        t_row t;
        t = '{default: '0};
        t.is_cfg = 1'b1;
        t.regs = '{a, b, c, d, e, f};
        dir_rows.push_back(t);
    endtask

    task automatic add_frame(t_in base, t_in centre, t_out exp);
        t_row t;
        for (int i = 0; i < 9; i++) begin
            t = '{default: '0};
            t.px = (i == 4) ? centre : base;
            t.px.frame_start = (i == 0);
            t.has_exp = (i == 8);
            t.exp = exp;
            dir_rows.push_back(t);
        end
    endtask

    // receiver
    initial begin
        int   gap;
        bit   held;
        bit   recv_idle_on;
        t_out e;
        held = 1'b0;
        recv_idle_on = 1'b1;
        out_ready = 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (n_got % 50 == 0) recv_idle_on = $urandom_range(0, 2) != 0;
            gap = recv_idle_on ? $urandom_range(0, 8) : 0;
            if (n_got == 30 && !held) begin
                held = 1'b1;
                gap = 400;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            n_got++;
            if (pixel_q.size() == 0) begin
                fails++;
                if (fails <= 10) $display("unexpected item %p", out_data);
            end else begin
                e = pixel_q.pop_front();
                if (out_data.red_out !== e.red_out || out_data.green_out !== e.green_out
                    || out_data.blue_out !== e.blue_out
                    || out_data.out_column !== e.out_column
                    || out_data.out_row !== e.out_row
                    || out_data.frame_end !== e.frame_end) begin
                    fails++;
                    if (fails <= 10) $display("mismatch exp %p got %p", e, out_data);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("conv3x3_rgb_clamp_divide_core test failed");
        $finish;
    end

    // stimulus
    initial begin
        logic [23:0] v [6];
        int unsigned w, h, tot, len, nfr;
        bit          fs;
        t_out        none;
        fails = 0;
        n_sent = 0;
        n_got = 0;
        n_phases = 0;
        send_idle_on = 1'b1;
        none = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        foreach (line_old[i]) begin
            line_old[i] = '0;
            line_new[i] = '0;
        end
        foreach (win_cols[i]) win_cols[i] = '0;
        pos_col = 0;
        pos_row = 0;
        max_idx_written = -1;
        k_top = 24'd0;
        k_mid = 24'h000100;
        k_bot = 24'd0;
        div_r = 8'd1;
        width_r = 11'd1024;
        height_r = 11'd1024;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // identity kernel at reset values, smallest frame
        add_cfg(24'd0, 24'h000100, 24'd0, 24'd1, 24'd3, 24'd3);
        add_frame(t_in'({8'd17, 8'd99, 8'd201, 1'b0}), t_in'({8'd255, 8'd0, 8'd128, 1'b0}),
                  t_out'({8'd255, 8'd0, 8'd128, 10'd1, 10'd1, 1'b1}));
        // largest positive taps, divisor zero
        add_cfg(24'h7f7f7f, 24'h7f7f7f, 24'h7f7f7f, 24'd0, 24'd3, 24'd3);
        add_frame(t_in'({8'd255, 8'd0, 8'd1, 1'b0}), t_in'({8'd255, 8'd0, 8'd1, 1'b0}),
                  t_out'({8'd255, 8'd0, 8'd255, 10'd1, 10'd1, 1'b1}));
        // most negative taps, largest divisor
        add_cfg(24'h808080, 24'h808080, 24'h808080, 24'd255, 24'd3, 24'd3);
        add_frame(t_in'({8'd255, 8'd255, 8'd255, 1'b0}), t_in'({8'd255, 8'd255, 8'd255, 1'b0}),
                  t_out'({8'd0, 8'd0, 8'd0, 10'd1, 10'd1, 1'b1}));
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) program_regs(dir_rows[i].regs);
            else send_px(dir_rows[i].px, dir_rows[i].has_exp, dir_rows[i].exp);
        end

        // saturated sizes: 1024 wide (border only here), then 3 wide and 1024 high
        program_regs('{24'h00ff01, 24'h7f0380, 24'h01fe02, 24'd7, 24'd2047, 24'd0});
        send_px(rand_px(1'b1), 1'b0, none);
        repeat (39) send_px(rand_px(1'b0), 1'b0, none);
        program_regs('{24'h010201, 24'h020402, 24'h010201, 24'd16, 24'd0, 24'd2047});
        send_px(rand_px(1'b1), 1'b0, none);
        repeat (59) send_px(rand_px(1'b0), 1'b0, none);

        while (n_sent < 930) begin
            send_idle_on = $urandom_range(0, 3) != 0;
            for (int i = 0; i < 3; i++) v[i] = {rand_coef(), rand_coef(), rand_coef()};
            case ($urandom_range(0, 7))
                0: v[3] = 24'd0;
                1: v[3] = 24'd255;
                2: v[3] = 24'd1;
                default: v[3] = $urandom_range(0, 255);
            endcase
            v[3] = noisy(v[3], 8);
            v[4] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
            v[5] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            v[4] = noisy(v[4], 11);
            v[5] = noisy(v[5], 11);
            program_regs(v);
            w = eff_dim(width_r);
            h = eff_dim(height_r);
            tot = w * h;
            nfr = $urandom_range(1, 3);
            for (int f = 0; f < nfr; f++) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, tot - 1) : tot;
                // carry on without a restart only where every stored column is defined
                fs = !(($urandom_range(0, 3) == 0) && (int'(w) <= max_idx_written + 1));
                for (int i = 0; i < len; i++) begin
                    send_px(rand_px(i == 0 ? fs : ($urandom_range(0, 63) == 0)), 1'b0, none);
                end
            end
        end

        in_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d pixels sent over %0d register settings, %0d filtered items checked",
                 n_sent, n_phases, n_got);
        if (fails == 0) begin
            $display("conv3x3_rgb_clamp_divide_core test passed");
        end else begin
            $display("%0d mismatches", fails);
            $display("conv3x3_rgb_clamp_divide_core test failed");
        end
        $finish;
    end

endmodule
